@@ hdl/dchc_pkg.sv @@
// Shared types and constants for the duplicate channel hit counter.
`default_nettype none

package dchc_pkg;

   typedef enum logic [1:0] {
      ACT_HIT   = 2'd0,
      ACT_SWEEP = 2'd1,
      ACT_READ  = 2'd2,
      ACT_SPARE = 2'd3
   } action_type;

   localparam int TALLY_W     = 2;
   localparam int TALLY_MAX   = 3;
   localparam int RSP_COUNT_W = 32;

endpackage

`default_nettype wire

@@ hdl/dchc_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none

module dchc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ hdl/dchc_map.sv @@
// Coordinate to channel index mapping with range check, registered.
`default_nettype none

module dchc_map #(
   parameter int UNIT_COLS   = 32,
   parameter int UNIT_ROWS   = 28,
   parameter int MODULE_COLS = 64,
   parameter int MODULE_ROWS = 56,
   parameter int GAIN_COUNT  = 2,
   localparam int CHANNELS   = MODULE_COLS * MODULE_ROWS * GAIN_COUNT,
   localparam int AW         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  wire logic          clock,
   input  wire logic          load,
   input  wire logic [4:0]    local_col,
   input  wire logic [4:0]    local_row,
   input  wire logic          unit_col,
   input  wire logic          unit_row,
   input  wire logic          gain_sel,
   output logic      [AW-1:0] idx_ff,
   output logic               err_ff
);

   localparam int COL_MAX = (31 + UNIT_COLS > MODULE_COLS) ? 31 + UNIT_COLS : MODULE_COLS;
   localparam int ROW_MAX = (31 + UNIT_ROWS > MODULE_ROWS) ? 31 + UNIT_ROWS : MODULE_ROWS;
   localparam int COL_W   = $clog2(COL_MAX + 1);
   localparam int ROW_W   = $clog2(ROW_MAX + 1);

   logic [COL_W-1:0] col;
   logic [ROW_W-1:0] row;
   logic [AW-1:0]    idx_in;
   logic             err_in;

   always_comb begin
      col    = COL_W'(local_col) + (unit_col ? COL_W'(UNIT_COLS) : '0);
      row    = ROW_W'(local_row) + (unit_row ? ROW_W'(UNIT_ROWS) : '0);
      err_in = (col >= COL_W'(MODULE_COLS)) || (row >= ROW_W'(MODULE_ROWS)) ||
               ((GAIN_COUNT < 2) && gain_sel);
      idx_in = (AW'(col) * AW'(MODULE_ROWS) + AW'(row)) * AW'(GAIN_COUNT) + AW'(gain_sel);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         idx_ff <= idx_in;
         err_ff <= err_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/dchc_satinc.sv @@
// Shared saturating incrementer for tallies and persistent counters.
`default_nettype none

module dchc_satinc #(
   parameter int WIDTH = 32
) (
   input  wire logic [WIDTH-1:0] operand,
   input  wire logic [WIDTH-1:0] limit,
   output logic      [WIDTH-1:0] result
);

   always_comb begin
      result = (operand >= limit) ? operand : operand + WIDTH'(1);
   end

endmodule

`default_nettype wire

@@ hdl/duplicate_channel_hit_counter.sv @@
// Top level: sequencer, tally and counter memories, shared incrementer.
`default_nettype none

// Hits, sweeps and reads are taken one at a time; busy is high while an item
// is in work and each item yields one rsp_valid strobe that cannot be held off.
// Hit and read: the request passes the channel map register and then the
// registered RAM read before the strobe, and a new item can be started in the
// strobe cycle. Out-of-range and spare codes are answered from the map state.
// End-of-event sweep (CHANNELS = MODULE_COLS*MODULE_ROWS*GAIN_COUNT, 7168 by
// default) runs one channel per cycle through the read-modify-write pipe of
// both RAMs, then a drain state. After reset a clearing pass over all CHANNELS
// zeroes both RAMs with busy high.
module duplicate_channel_hit_counter #(
   parameter int UNIT_COLS    = 32,
   parameter int UNIT_ROWS    = 28,
   parameter int MODULE_COLS  = 64,
   parameter int MODULE_ROWS  = 56,
   parameter int GAIN_COUNT   = 2,
   parameter int COUNTER_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic [4:0]  req_local_col,
   input  wire logic [4:0]  req_local_row,
   input  wire logic        req_unit_col,
   input  wire logic        req_unit_row,
   input  wire logic        req_gain_sel,
   output logic             rsp_valid,
   output logic [31:0]      rsp_count_value,
   output logic             rsp_range_error
);

   localparam int CHANNELS = MODULE_COLS * MODULE_ROWS * GAIN_COUNT;
   localparam int AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int EXT_W    = (COUNTER_BITS > dchc_pkg::RSP_COUNT_W) ?
                             COUNTER_BITS : dchc_pkg::RSP_COUNT_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAP,
      ST_LOOK,
      ST_SWEEP,
      ST_DRAIN
   } state_type;

   state_type            state_ff, state_in;
   dchc_pkg::action_type action_ff, action_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [AW-1:0]        wb_addr_ff, wb_addr_in;
   logic                 wb_valid_ff, wb_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_count_ff, rsp_count_in;
   logic                 rsp_err_ff, rsp_err_in;

   logic                 accept;
   logic [AW-1:0]        map_idx;
   logic                 map_err;

   logic                         tally_we;
   logic [AW-1:0]                tally_waddr;
   logic [dchc_pkg::TALLY_W-1:0] tally_wdata;
   logic [AW-1:0]                rd_addr;
   logic [dchc_pkg::TALLY_W-1:0] tally_rdata;
   logic                         cnt_we;
   logic [AW-1:0]                cnt_waddr;
   logic [COUNTER_BITS-1:0]      cnt_wdata;
   logic [COUNTER_BITS-1:0]      cnt_rdata;

   logic [COUNTER_BITS-1:0]      inc_operand;
   logic [COUNTER_BITS-1:0]      inc_limit;
   logic [COUNTER_BITS-1:0]      inc_result;
   logic [EXT_W-1:0]             cnt_ext;

   assign busy            = (state_ff != ST_IDLE);
   assign accept          = start && !busy;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_count_value = rsp_count_ff;
   assign rsp_range_error = rsp_err_ff;

   dchc_map #(
      .UNIT_COLS   (UNIT_COLS),
      .UNIT_ROWS   (UNIT_ROWS),
      .MODULE_COLS (MODULE_COLS),
      .MODULE_ROWS (MODULE_ROWS),
      .GAIN_COUNT  (GAIN_COUNT)
   ) u_map (
      .clock     (clock),
      .load      (accept),
      .local_col (req_local_col),
      .local_row (req_local_row),
      .unit_col  (req_unit_col),
      .unit_row  (req_unit_row),
      .gain_sel  (req_gain_sel),
      .idx_ff    (map_idx),
      .err_ff    (map_err)
   );

   dchc_ram #(
      .WIDTH (dchc_pkg::TALLY_W),
      .DEPTH (CHANNELS)
   ) u_tally_ram (
      .clock   (clock),
      .wr_en   (tally_we),
      .wr_addr (tally_waddr),
      .wr_data (tally_wdata),
      .rd_addr (rd_addr),
      .rd_data (tally_rdata)
   );

   dchc_ram #(
      .WIDTH (COUNTER_BITS),
      .DEPTH (CHANNELS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (rd_addr),
      .rd_data (cnt_rdata)
   );

   dchc_satinc #(
      .WIDTH (COUNTER_BITS)
   ) u_satinc (
      .operand (inc_operand),
      .limit   (inc_limit),
      .result  (inc_result)
   );

   // memory ports and shared incrementer
   always_comb begin
      rd_addr     = (state_ff == ST_SWEEP) ? addr_ff : map_idx;
      inc_operand = (state_ff == ST_LOOK) ? COUNTER_BITS'(tally_rdata) : cnt_rdata;
      inc_limit   = (state_ff == ST_LOOK) ? COUNTER_BITS'(dchc_pkg::TALLY_MAX) : '1;
      cnt_ext     = EXT_W'(cnt_rdata);

      tally_we    = 1'b0;
      tally_waddr = wb_addr_ff;
      tally_wdata = '0;
      cnt_we      = 1'b0;
      cnt_waddr   = wb_addr_ff;
      cnt_wdata   = inc_result;

      if (state_ff == ST_CLEAR) begin
         tally_we    = 1'b1;
         tally_waddr = addr_ff;
         cnt_we      = 1'b1;
         cnt_waddr   = addr_ff;
         cnt_wdata   = '0;
      end else if (state_ff == ST_LOOK && action_ff == dchc_pkg::ACT_HIT) begin
         tally_we    = 1'b1;
         tally_waddr = map_idx;
         tally_wdata = inc_result[dchc_pkg::TALLY_W-1:0];
      end else if (wb_valid_ff) begin
         tally_we = 1'b1;
         cnt_we   = (tally_rdata > dchc_pkg::TALLY_W'(1));
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      addr_in      = addr_ff;
      wb_addr_in   = wb_addr_ff;
      wb_valid_in  = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_count_in = rsp_count_ff;
      rsp_err_in   = rsp_err_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            addr_in = addr_ff + AW'(1);
            if (addr_ff == AW'(CHANNELS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               action_in = dchc_pkg::action_type'(req_action);
               state_in  = ST_MAP;
            end
         end
         ST_MAP: begin
            addr_in = '0;
            case (action_ff)
               dchc_pkg::ACT_SWEEP: begin
                  state_in = ST_SWEEP;
               end
               dchc_pkg::ACT_HIT, dchc_pkg::ACT_READ: begin
                  if (map_err) begin
                     rsp_valid_in = 1'b1;
                     rsp_count_in = '0;
                     rsp_err_in   = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     state_in = ST_LOOK;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = '0;
                  rsp_err_in   = 1'b0;
                  state_in     = ST_IDLE;
               end
            endcase
         end
         ST_LOOK: begin
            rsp_valid_in = 1'b1;
            rsp_err_in   = 1'b0;
            rsp_count_in = (action_ff == dchc_pkg::ACT_READ) ? cnt_ext[31:0] : '0;
            state_in     = ST_IDLE;
         end
         ST_SWEEP: begin
            wb_valid_in = 1'b1;
            wb_addr_in  = addr_ff;
            addr_in     = addr_ff + AW'(1);
            if (addr_ff == AW'(CHANNELS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            rsp_valid_in = 1'b1;
            rsp_count_in = '0;
            rsp_err_in   = 1'b0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         wb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         wb_valid_ff  <= wb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff    <= action_in;
      wb_addr_ff   <= wb_addr_in;
      rsp_count_ff <= rsp_count_in;
      rsp_err_ff   <= rsp_err_in;
   end

endmodule

`default_nettype wire
